// ----- sv/rv32_subset_execute_unit_core_macros.svh -----
// Assertion macros shared by the execute unit RTL.
`ifndef RV32_SUBSET_EXECUTE_UNIT_CORE_MACROS_SVH
`define RV32_SUBSET_EXECUTE_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVX_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RVX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rvx_pkg.sv -----
// Shared types, operation codes and constants for the execute unit.
package rvx_pkg;

  localparam int unsigned XLEN          = 32;
  localparam int unsigned NREGS         = 32;
  localparam int unsigned RIDX_W        = $clog2(NREGS);
  localparam int unsigned MEM_WORDS_DEF = 1024;

  typedef enum logic [4:0] {
    OP_LI    = 5'd0,
    OP_ADDI  = 5'd1,
    OP_ADD   = 5'd2,
    OP_SUB   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_SLLI  = 5'd7,
    OP_SRLI  = 5'd8,
    OP_SRAI  = 5'd9,
    OP_SLL   = 5'd10,
    OP_SRL   = 5'd11,
    OP_SRA   = 5'd12,
    OP_SLTU  = 5'd13,
    OP_SLTIU = 5'd14,
    OP_ORI   = 5'd15,
    OP_XORI  = 5'd16,
    OP_LW    = 5'd17,
    OP_SW    = 5'd18
  } op_e;

  typedef struct packed {
    logic [4:0]             operation;
    logic [RIDX_W-1:0]      dest_reg;
    logic [RIDX_W-1:0]      src1_reg;
    logic [RIDX_W-1:0]      src2_reg;
    logic signed [XLEN-1:0] immediate;
  } req_t;

  typedef struct packed {
    logic [XLEN-1:0] write_value;
    logic            reg_written;
    logic [XLEN-1:0] next_pc;
  } rsp_t;

  // One register file write, also kept as the forwarding source.
  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage

// ----- sv/rvx_regfile.sv -----
// Register file: two registered read ports, one write port, per-entry valid bits.
module rvx_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [rvx_pkg::RIDX_W-1:0]    raddr_a_i,
  input  logic [rvx_pkg::RIDX_W-1:0]    raddr_b_i,
  output logic [rvx_pkg::XLEN-1:0]      rdata_a_o,
  output logic [rvx_pkg::XLEN-1:0]      rdata_b_o,
  input  rvx_pkg::rf_wr_t               wr_i
);
  import rvx_pkg::*;

  logic [XLEN-1:0] mem [NREGS];
  logic [NREGS-1:0] valid_q;
  logic [XLEN-1:0] rdata_a_q;
  logic [XLEN-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // An entry never written since reset reads as zero; x0 is never written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_a_q <= valid_q[raddr_a_i] ? mem[raddr_a_i] : '0;
      rdata_b_q <= valid_q[raddr_b_i] ? mem[raddr_b_i] : '0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- sv/rvx_dmem.sv -----
// Data memory: one registered read port, one write port, zeroing sweep after reset.
module rvx_dmem #(
  parameter int unsigned MEM_WORDS = rvx_pkg::MEM_WORDS_DEF,
  localparam int unsigned AW = $clog2(MEM_WORDS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  output logic                     ready_o,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [rvx_pkg::XLEN-1:0] rdata_o,
  input  logic                     st_en_i,
  input  logic [AW-1:0]            st_addr_i,
  input  logic [rvx_pkg::XLEN-1:0] st_data_i
);
  import rvx_pkg::*;

  logic [XLEN-1:0] mem [MEM_WORDS];
  logic [XLEN-1:0] rdata_q;
  logic            clr_busy_q, clr_busy_d;
  logic [AW-1:0]   clr_idx_q, clr_idx_d;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [XLEN-1:0] wdata;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + AW'(1);
      if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  assign we    = clr_busy_q | st_en_i;
  assign waddr = clr_busy_q ? clr_idx_q : st_addr_i;
  assign wdata = clr_busy_q ? '0 : st_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign ready_o = !clr_busy_q;
  assign rdata_o = rdata_q;

endmodule

// ----- sv/rvx_alu.sv -----
// Execute datapath: computes the result value and the register write flag.
module rvx_alu (
  input  logic [4:0]               op_i,
  input  logic [rvx_pkg::XLEN-1:0] a_i,
  input  logic [rvx_pkg::XLEN-1:0] b_i,
  input  logic [rvx_pkg::XLEN-1:0] imm_i,
  input  logic [rvx_pkg::XLEN-1:0] mem_data_i,
  input  logic                     in_mem_i,
  output logic [rvx_pkg::XLEN-1:0] val_o,
  output logic                     writes_o
);
  import rvx_pkg::*;

  logic [4:0] ish;
  logic [4:0] rsh;

  assign ish = imm_i[4:0];
  assign rsh = b_i[4:0];

  always_comb begin
    val_o    = '0;
    writes_o = 1'b1;
    unique case (op_e'(op_i))
      OP_LI:    val_o = imm_i;
      OP_ADDI:  val_o = a_i + imm_i;
      OP_ADD:   val_o = a_i + b_i;
      OP_SUB:   val_o = a_i - b_i;
      OP_AND:   val_o = a_i & b_i;
      OP_OR:    val_o = a_i | b_i;
      OP_XOR:   val_o = a_i ^ b_i;
      OP_SLLI:  val_o = a_i << ish;
      OP_SRLI:  val_o = a_i >> ish;
      OP_SRAI:  val_o = $unsigned($signed(a_i) >>> ish);
      OP_SLL:   val_o = a_i << rsh;
      OP_SRL:   val_o = a_i >> rsh;
      OP_SRA:   val_o = $unsigned($signed(a_i) >>> rsh);
      OP_SLTU:  val_o = {{(XLEN-1){1'b0}}, a_i < b_i};
      OP_SLTIU: val_o = {{(XLEN-1){1'b0}}, a_i < imm_i};
      OP_ORI:   val_o = a_i | imm_i;
      OP_XORI:  val_o = a_i ^ imm_i;
      OP_LW:    val_o = in_mem_i ? mem_data_i : '0;
      OP_SW: begin
        // The second read port carries the store data register.
        val_o    = b_i;
        writes_o = 1'b0;
      end
      default: begin
        val_o    = '0;
        writes_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/rv32_subset_execute_unit_core.sv -----
// Top level of the execute unit: read stage, execute/commit stage and output register.
// An accepted request is registered in the read stage (s1 and register file data),
// then executed and committed into the output register once the output is free.
// Throughput: one request per cycle unless output stalls (read-execute-write loop).
// Reset clears the register file (valid bits) and the PC at once; the data memory
// is then zeroed one word a cycle, and no request is taken until the sweep ends.
`include "rv32_subset_execute_unit_core_macros.svh"

module rv32_subset_execute_unit_core #(
  parameter int unsigned MEM_WORDS = rvx_pkg::MEM_WORDS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rvx_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rvx_pkg::rsp_t out_rsp_o
);
  import rvx_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic              accept;
  logic              commit;
  logic              dmem_ready;
  logic [RIDX_W-1:0] rb_addr;
  logic              req_in_mem;

  logic              s1_valid_q, s1_valid_d;
  logic [4:0]        s1_op_q;
  logic [RIDX_W-1:0] s1_rd_q;
  logic [RIDX_W-1:0] s1_ra_q;
  logic [RIDX_W-1:0] s1_rb_q;
  logic [XLEN-1:0]   s1_imm_q;
  logic              s1_in_mem_q;
  logic [AW-1:0]     s1_word_q;

  logic [XLEN-1:0]   rf_a, rf_b, op_a, op_b;
  logic [XLEN-1:0]   mem_rdata, mem_data;
  logic [XLEN-1:0]   alu_val;
  logic              alu_writes;
  logic              st_en;

  rf_wr_t            rf_wr;
  rf_wr_t            last_wr_q;
  logic              last_st_en_q;
  logic [AW-1:0]     last_st_addr_q;
  logic [XLEN-1:0]   last_st_data_q;

  logic [XLEN-1:0]   pc_q, pc_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_rsp_q;

  assign commit     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = dmem_ready && (!s1_valid_q || commit);
  assign accept     = in_valid_i && in_ready_o;

  assign rb_addr    = (op_e'(in_req_i.operation) == OP_SW) ? in_req_i.dest_reg
                                                           : in_req_i.src2_reg;
  assign req_in_mem = in_req_i.immediate[XLEN-1:2] < (XLEN-2)'(MEM_WORDS);

  rvx_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .raddr_a_i (in_req_i.src1_reg),
    .raddr_b_i (rb_addr),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b),
    .wr_i      (rf_wr)
  );

  rvx_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ready_o   (dmem_ready),
    .rd_en_i   (accept && req_in_mem),
    .raddr_i   (in_req_i.immediate[AW+1:2]),
    .rdata_o   (mem_rdata),
    .st_en_i   (st_en),
    .st_addr_i (s1_word_q),
    .st_data_i (op_b)
  );

  // The read at accept misses a write committed at that same edge, so the most
  // recent register and memory writes are kept and forwarded on a match.
  assign op_a = (last_wr_q.en && last_wr_q.addr == s1_ra_q) ? last_wr_q.data : rf_a;
  assign op_b = (last_wr_q.en && last_wr_q.addr == s1_rb_q) ? last_wr_q.data : rf_b;
  assign mem_data = (last_st_en_q && last_st_addr_q == s1_word_q) ? last_st_data_q
                                                                 : mem_rdata;

  rvx_alu u_alu (
    .op_i       (s1_op_q),
    .a_i        (op_a),
    .b_i        (op_b),
    .imm_i      (s1_imm_q),
    .mem_data_i (mem_data),
    .in_mem_i   (s1_in_mem_q),
    .val_o      (alu_val),
    .writes_o   (alu_writes)
  );

  assign rf_wr.en   = commit && alu_writes && (s1_rd_q != '0);
  assign rf_wr.addr = s1_rd_q;
  assign rf_wr.data = alu_val;
  assign st_en      = commit && (op_e'(s1_op_q) == OP_SW) && s1_in_mem_q;

  assign s1_valid_d  = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_q);
  assign out_valid_d = commit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign pc_d        = commit ? pc_q + XLEN'(4) : pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pc_q         <= '0;
      last_wr_q    <= '0;
      last_st_en_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pc_q        <= pc_d;
      if (rf_wr.en) begin
        last_wr_q <= rf_wr;
      end
      if (st_en) begin
        last_st_en_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= in_req_i.operation;
      s1_rd_q     <= in_req_i.dest_reg;
      s1_ra_q     <= in_req_i.src1_reg;
      s1_rb_q     <= rb_addr;
      s1_imm_q    <= $unsigned(in_req_i.immediate);
      s1_in_mem_q <= req_in_mem;
      s1_word_q   <= in_req_i.immediate[AW+1:2];
    end
    if (st_en) begin
      last_st_addr_q <= s1_word_q;
      last_st_data_q <= op_b;
    end
    if (commit) begin
      out_rsp_q.write_value <= alu_val;
      out_rsp_q.reg_written <= alu_writes;
      out_rsp_q.next_pc     <= pc_q + XLEN'(4);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `RVX_ASSERT_IMPL(a_no_accept_while_clearing, clk_i, rst_ni, accept, dmem_ready,
                   "request accepted during memory clear")
  `RVX_ASSERT_IMPL(a_no_write_x0, clk_i, rst_ni, rf_wr.en, rf_wr.addr != '0,
                   "register x0 written")
  `RVX_ASSERT_NEXT(a_pc_steps, clk_i, rst_ni, commit, pc_q == $past(pc_q) + XLEN'(4),
                   "pc did not advance by four on commit")
  `RVX_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !commit,
                   s1_valid_q && $stable(s1_op_q) && $stable(s1_imm_q),
                   "stalled execute stage changed")

endmodule
